// ===== hdl/bia_pkg.sv =====
// Shared types and constants of the bitmap index allocator.
// Field widths, operation and status codes, controller/datapath command and status structs.
// No dependencies.
package bia_pkg;

	localparam int INDEX_W    = 16;
	localparam int COUNT_W    = 9;
	localparam int KIND_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int WORD_BITS  = 8;
	localparam int BIT_W      = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	typedef logic [KIND_W-1:0]    kind_t;
	typedef logic [STATUS_W-1:0]  status_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam kind_t KIND_ALLOC = 2'd0;
	localparam kind_t KIND_FREE  = 2'd1;
	localparam kind_t KIND_QUERY = 2'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NONE_FREE = 2'd1;
	localparam status_t ST_RANGE     = 2'd2;

	localparam cfg_idx_t CFG_BASE  = 1'd0;
	localparam cfg_idx_t CFG_COUNT = 1'd1;

	localparam logic [INDEX_W-1:0] BASE_RESET  = 16'd0;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_NONE_FREE,
		RES_RANGE,
		RES_GRANT,
		RES_FREE,
		RES_QUERY
	} res_sel_t;

	typedef enum logic {
		RD_TARGET,
		RD_NEXT
	} rd_sel_t;

	typedef struct packed {
		logic     latch_op;
		logic     latch_cur;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_set;
		logic     wr_clr;
		logic     clr_wr;
		logic     scan_first;
		logic     scan_step;
		logic     res_load;
		res_sel_t res_sel;
		logic     emit;
	} bia_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  range_ok;
		logic  exhausted;
		logic  found;
		logic  home;
		logic  clr_done;
		logic  out_free;
	} bia_stat_t;

endpackage

// ===== hdl/bia_ctrl.sv =====
// Controller of the bitmap index allocator: sequences clear pass, allocate scan,
// free read-modify-write, query read, and result transfer. Depends on bia_pkg.
module bia_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                cfg_we,
	input  bia_pkg::bia_stat_t  stat,
	output bia_pkg::bia_cmd_t   cmd,
	output logic                s_tready
);
	import bia_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_ALLOC_WR,
		S_SCAN,
		S_FREE_WR,
		S_QUERY,
		S_EMIT
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.latch_op = s_tvalid;
				if (s_tvalid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (stat.kind)
					KIND_ALLOC: begin
						if (stat.exhausted) begin
							cmd.res_load = 1'b1;
							cmd.res_sel  = RES_NONE_FREE;
							state_d      = S_EMIT;
						end else begin
							cmd.latch_cur = 1'b1;
							cmd.rd_en     = 1'b1;
							cmd.rd_sel    = RD_TARGET;
							state_d       = S_ALLOC_WR;
						end
					end
					KIND_FREE, KIND_QUERY: begin
						if (stat.range_ok) begin
							cmd.latch_cur = 1'b1;
							cmd.rd_en     = 1'b1;
							cmd.rd_sel    = RD_TARGET;
							state_d       = (stat.kind == KIND_FREE) ? S_FREE_WR : S_QUERY;
						end else begin
							cmd.res_load = 1'b1;
							cmd.res_sel  = RES_RANGE;
							state_d      = S_EMIT;
						end
					end
					default: begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_ZERO;
						state_d      = S_EMIT;
					end
				endcase
			end
			S_ALLOC_WR: begin
				cmd.wr_set     = 1'b1;
				cmd.scan_first = 1'b1;
				cmd.res_load   = 1'b1;
				cmd.res_sel    = RES_GRANT;
				if (stat.found) begin
					state_d = S_EMIT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
					state_d    = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.found || stat.home) begin
					state_d = S_EMIT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
				end
			end
			S_FREE_WR: begin
				cmd.wr_clr   = 1'b1;
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_FREE;
				state_d      = S_EMIT;
			end
			S_QUERY: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_QUERY;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (cfg_we) begin
			cmd     = '0;
			state_d = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/bia_dpath.sv =====
// Datapath of the bitmap index allocator: config registers, used-bit map memory,
// next-free pointer, word scan logic, result and output registers. Depends on bia_pkg.
module bia_dpath #(
	parameter int SLOTS = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  bia_pkg::cfg_idx_t                     cfg_index,
	input  logic [bia_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  bia_pkg::kind_t                        in_kind,
	input  logic [bia_pkg::INDEX_W-1:0]           in_index,
	input  bia_pkg::bia_cmd_t                     cmd,
	output bia_pkg::bia_stat_t                    stat,
	input  logic                                  m_tready,
	output logic                                  out_valid,
	output logic [bia_pkg::INDEX_W-1:0]           out_granted,
	output bia_pkg::status_t                      out_status,
	output logic                                  out_in_use
);
	import bia_pkg::*;

	localparam int WORDS  = (SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SLOT_W = ADDR_W + BIT_W;

	logic [WORD_BITS-1:0] mem [WORDS];
	logic [WORD_BITS-1:0] rd_q;

	logic [INDEX_W-1:0] base_q;
	logic [COUNT_W-1:0] count_q;
	logic [SLOT_W-1:0]  next_q;
	logic               exh_q;
	kind_t              kind_q;
	logic [INDEX_W-1:0] idx_q;
	logic [SLOT_W-1:0]  cur_q;
	logic [ADDR_W-1:0]  scan_q;
	logic [ADDR_W-1:0]  clr_q;

	logic [INDEX_W-1:0] res_granted_q;
	status_t            res_status_q;
	logic               res_in_use_q;
	logic               out_valid_q;
	logic [INDEX_W-1:0] out_granted_q;
	status_t            out_status_q;
	logic               out_in_use_q;

	logic [COUNT_W-1:0]   cnt;
	logic [INDEX_W:0]     diff;
	logic                 range_ok;
	logic [SLOT_W-1:0]    req_slot;
	logic [SLOT_W-1:0]    alloc_cur;
	logic [SLOT_W-1:0]    target;
	logic [ADDR_W-1:0]    last_word;
	logic [ADDR_W-1:0]    next_word;
	logic [ADDR_W-1:0]    rd_addr;
	logic [ADDR_W-1:0]    home_word;
	logic [BIT_W-1:0]     home_bit;
	logic [WORD_BITS-1:0] cur_mask;
	logic [WORD_BITS-1:0] cand;
	logic [BIT_W-1:0]     pos;
	logic                 found;
	logic                 home;

	always_comb begin
		if (count_q == '0) begin
			cnt = COUNT_W'(1);
		end else if (32'(count_q) > SLOTS) begin
			cnt = COUNT_W'(SLOTS);
		end else begin
			cnt = count_q;
		end
	end

	assign diff      = {1'b0, idx_q} - {1'b0, base_q};
	assign range_ok  = !diff[INDEX_W] && (diff[INDEX_W-1:0] < INDEX_W'(cnt));
	assign req_slot  = SLOT_W'(diff[INDEX_W-1:0]);
	assign alloc_cur = (32'(next_q) >= 32'(cnt)) ? '0 : next_q;
	assign target    = (kind_q == KIND_ALLOC) ? alloc_cur : req_slot;
	assign last_word = ADDR_W'((32'(cnt) - 32'd1) >> BIT_W);
	assign next_word = (scan_q == last_word) ? '0 : scan_q + ADDR_W'(1);
	assign rd_addr   = (cmd.rd_sel == RD_TARGET) ? target[SLOT_W-1:BIT_W] : next_word;
	assign home_word = cur_q[SLOT_W-1:BIT_W];
	assign home_bit  = cur_q[BIT_W-1:0];
	assign home      = (scan_q == home_word);
	assign cur_mask  = WORD_BITS'(1) << home_bit;

	// free slots of the word just read, limited to the count and to the part of the ring
	// that this step covers
	always_comb begin
		logic in_cnt;
		logic in_arc;
		cand = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			in_cnt = (32'({scan_q, BIT_W'(i)}) < 32'(cnt));
			if (cmd.scan_first) begin
				in_arc = (BIT_W'(i) > home_bit);
			end else begin
				in_arc = home ? (BIT_W'(i) < home_bit) : 1'b1;
			end
			cand[i] = !rd_q[i] && in_cnt && in_arc;
		end
	end

	always_comb begin
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (cand[i]) pos = BIT_W'(i);
		end
	end

	assign found = |cand;

	assign stat.kind      = kind_q;
	assign stat.range_ok  = range_ok;
	assign stat.exhausted = exh_q;
	assign stat.found     = found;
	assign stat.home      = home;
	assign stat.clr_done  = (clr_q == ADDR_W'(WORDS - 1));
	assign stat.out_free  = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.rd_en) rd_q <= mem[rd_addr];
		if (cmd.clr_wr) begin
			mem[clr_q] <= '0;
		end else if (cmd.wr_set) begin
			mem[home_word] <= rd_q | cur_mask;
		end else if (cmd.wr_clr) begin
			mem[home_word] <= rd_q & ~cur_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_RESET;
			count_q <= COUNT_RESET;
			next_q  <= '0;
			exh_q   <= 1'b0;
			clr_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE:  base_q  <= cfg_data;
				CFG_COUNT: count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
			next_q <= '0;
			exh_q  <= 1'b0;
			clr_q  <= '0;
		end else begin
			if (cmd.clr_wr) clr_q <= clr_q + ADDR_W'(1);
			if ((cmd.scan_first || cmd.scan_step) && found) begin
				next_q <= {scan_q, pos};
			end else if (cmd.scan_step && home) begin
				next_q <= cur_q;
				exh_q  <= 1'b1;
			end
			if (cmd.wr_clr && ((cur_q < next_q) || exh_q)) begin
				next_q <= cur_q;
				exh_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_op) begin
			kind_q <= in_kind;
			idx_q  <= in_index;
		end
		if (cmd.latch_cur) cur_q <= target;
		if (cmd.rd_en) scan_q <= rd_addr;
		if (cmd.res_load) begin
			res_granted_q <= '0;
			res_status_q  <= ST_OK;
			res_in_use_q  <= 1'b0;
			case (cmd.res_sel)
				RES_NONE_FREE: res_status_q  <= ST_NONE_FREE;
				RES_RANGE:     res_status_q  <= ST_RANGE;
				RES_GRANT:     res_granted_q <= base_q + INDEX_W'(cur_q);
				RES_QUERY:     res_in_use_q  <= rd_q[home_bit];
				default: ;
			endcase
		end
		if (cmd.emit) begin
			out_granted_q <= res_granted_q;
			out_status_q  <= res_status_q;
			out_in_use_q  <= res_in_use_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_granted = out_granted_q;
	assign out_status  = out_status_q;
	assign out_in_use  = out_in_use_q;

endmodule

// ===== hdl/bitmap_index_allocator_core.sv =====
// Top level of the bitmap index allocator: stream ports, config port, controller and datapath.
// Depends on bia_pkg, bia_ctrl, bia_dpath.
//
// Next-fit allocator over base_index .. base_index+slot_count-1, one result per request.
// After reset and after every config write the used map is cleared one map word per cycle,
// during which no request is taken. Out-of-range, unknown and exhausted allocate requests
// skip the map access; free and query requests read the map word of their slot, and a free
// writes it back. An allocate reads the word of the next-free pointer, then the circular
// search for the next free slot reads one map word at a time through the single read port
// of the map memory, at most ceil(slot_count/8) words. A new request is taken while the
// previous result still waits in the output register.
module bitmap_index_allocator_core #(
	parameter int SLOTS = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [15:0]                        s_tdata,   // [15:0] index
	input  logic [1:0]                         s_tuser,   // [1:0] kind
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [23:0]                        m_tdata,   // [15:0] granted_index,
	                                                      // [17:16] status, [18] in_use
	input  logic                               cfg_we,
	input  bia_pkg::cfg_idx_t                  cfg_index,
	input  logic [bia_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bia_pkg::*;

	bia_cmd_t           cmd;
	bia_stat_t          stat;
	logic [INDEX_W-1:0] out_granted;
	status_t            out_status;
	logic               out_in_use;

	bia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.cfg_we   (cfg_we),
		.stat     (stat),
		.cmd      (cmd),
		.s_tready (s_tready)
	);

	bia_dpath #(
		.SLOTS (SLOTS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_kind     (s_tuser),
		.in_index    (s_tdata),
		.cmd         (cmd),
		.stat        (stat),
		.m_tready    (m_tready),
		.out_valid   (m_tvalid),
		.out_granted (out_granted),
		.out_status  (out_status),
		.out_in_use  (out_in_use)
	);

	assign m_tdata = {5'd0, out_in_use, out_status, out_granted};

	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !s_tready)
		else $error("request taken during map clear");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("pending result overwritten");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_set, cmd.wr_clr, cmd.clr_wr}))
		else $error("two map writes in one cycle");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("result not presented after load");

endmodule
